>>> rtl/core/vertical_counter_debouncer_top_macros.svh
`ifndef VERTICAL_COUNTER_DEBOUNCER_TOP_MACROS_SVH
`define VERTICAL_COUNTER_DEBOUNCER_TOP_MACROS_SVH

// Clocked on clk, quiet while rst is high.
`define VCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define VCD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/core/vcd_pkg.sv
`timescale 1ns / 1ps

package vcd_pkg;

  localparam int MAX_PORTS = 4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [7:0] COUNT_RESET = 8'hFF;

  typedef struct packed {
    logic       op;
    logic [7:0] pin_levels;
    logic [2:0] pin;
  } vcd_cmd_t;

  typedef struct packed {
    logic       pressed;
    logic [7:0] debounced_state;
  } vcd_rsp_t;

endpackage

>>> rtl/core/vcd_port.sv
`timescale 1ns / 1ps

module vcd_port (
  input  logic               clk,
  input  logic               rst,
  input  logic               sel,
  input  logic               enable,
  input  vcd_pkg::vcd_cmd_t  cmd,
  output vcd_pkg::vcd_rsp_t  rsp
);

  logic [7:0] stable_state, stable_state_next;
  logic [7:0] count_low, count_low_next;
  logic [7:0] count_high, count_high_next;
  logic [7:0] press_latch, press_latch_next;

  logic [7:0] diff, lo, hi, wrapped, stable_upd, hit;

  always_comb begin
    diff       = ~cmd.pin_levels ^ stable_state;
    lo         = ~(count_low & diff);
    hi         = lo ^ (count_high & diff);
    wrapped    = diff & hi & lo;
    stable_upd = stable_state ^ wrapped;
    hit        = press_latch & (8'b1 << cmd.pin);

    stable_state_next = stable_state;
    count_low_next    = count_low;
    count_high_next   = count_high;
    press_latch_next  = press_latch;
    rsp.pressed       = 1'b0;

    unique case (cmd.op)
      vcd_pkg::OP_SAMPLE: begin
        if (enable) begin
          stable_state_next = stable_upd;
          count_low_next    = lo;
          count_high_next   = hi;
          press_latch_next  = press_latch | (stable_upd & wrapped);
        end
      end
      vcd_pkg::OP_READ: begin
        press_latch_next = press_latch ^ hit;
        rsp.pressed      = |hit;
      end
      default: begin
        rsp.pressed = 1'b0;
      end
    endcase

    rsp.debounced_state = stable_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_state <= '0;
      count_low    <= vcd_pkg::COUNT_RESET;
      count_high   <= vcd_pkg::COUNT_RESET;
      press_latch  <= '0;
    end else if (sel) begin
      stable_state <= stable_state_next;
      count_low    <= count_low_next;
      count_high   <= count_high_next;
      press_latch  <= press_latch_next;
    end
  end

endmodule

>>> rtl/core/vertical_counter_debouncer_top.sv
`timescale 1ns / 1ps
// Debouncer for eight active-low buttons on each of up to four ports.
// Input stream (s_axis): one request per item. tuser = 0 samples a port's raw
// pins, tuser = 1 reads and clears one pin's latched press.
// Output stream (m_axis): exactly one result per request, in request order.
// cfg_we/cfg_data write the port enable mask; sampling of a disabled port
// leaves its state alone, reads still work. Write it only while idle.
// Path: a request passes the input register, then the result register,
// before its result shows on m_axis.
// Throughput: one request per cycle unless m_axis stalls; all per-port work is
// bitwise logic on the addressed port's registers between the two registers.
// Reset (rst, synchronous): all pins released, counters at three, press
// latches and enables cleared, both stages empty.
// When m_axis stalls, the result register holds and the input register
// fills; s_axis_tready drops only when both are full.
// Requests addressing a port at or beyond PORTS return all zeros.

`include "vertical_counter_debouncer_top_macros.svh"

module vertical_counter_debouncer_top #(
  parameter int PORTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // port[1:0], pin_levels[9:2], pin[12:10]
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // pressed[0], debounced_state[8:1]
);

  localparam int LANES = (PORTS < vcd_pkg::MAX_PORTS) ? PORTS : vcd_pkg::MAX_PORTS;

  logic [3:0] port_enable;

  logic               s1_valid;
  logic [1:0]         s1_port;
  vcd_pkg::vcd_cmd_t  s1_cmd;
  logic               s1_fire;
  logic               out_ok;
  logic               s1_sample;
  logic               s1_unmapped;

  logic               m_valid;
  vcd_pkg::vcd_rsp_t  m_rsp;

  logic [LANES-1:0]   lane_sel;
  vcd_pkg::vcd_rsp_t  lane_rsp [LANES];
  vcd_pkg::vcd_rsp_t  rsp_sel;

  assign out_ok        = !m_valid || m_axis_tready;
  assign s1_fire       = s1_valid && out_ok;
  assign s_axis_tready = !s1_valid || out_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_enable <= '0;
    end else if (cfg_we) begin
      port_enable <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_port           <= s_axis_tdata[1:0];
      s1_cmd.op         <= s_axis_tuser;
      s1_cmd.pin_levels <= s_axis_tdata[9:2];
      s1_cmd.pin        <= s_axis_tdata[12:10];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_port
    assign lane_sel[i] = (s1_port == 2'(i));

    vcd_port u_port (
      .clk    (clk),
      .rst    (rst),
      .sel    (s1_fire && lane_sel[i]),
      .enable (port_enable[i]),
      .cmd    (s1_cmd),
      .rsp    (lane_rsp[i])
    );
  end

  always_comb begin
    rsp_sel = '0;
    for (int i = 0; i < LANES; i++) begin
      if (lane_sel[i]) begin
        rsp_sel = rsp_sel | lane_rsp[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_ok) begin
      m_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_rsp <= rsp_sel;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'b0, m_rsp.debounced_state, m_rsp.pressed};

  assign s1_sample   = s1_fire && (s1_cmd.op == vcd_pkg::OP_SAMPLE);
  assign s1_unmapped = s1_fire && (32'(s1_port) >= LANES);

  `VCD_ASSERT(a_fire_gives_result, s1_fire |=> m_axis_tvalid, "result missing after issue")
  `VCD_ASSERT(a_sample_no_press, s1_sample |=> !m_axis_tdata[0], "sample reported a press")
  `VCD_ASSERT(a_bad_port_zero, s1_unmapped |=> (m_axis_tdata == '0), "unmapped port data")
  `VCD_ASSERT_NEVER(a_no_overrun, s1_valid && !s1_fire && s_axis_tready, "input overrun")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 6;

  class debounce_scoreboard;
    logic [3:0] enable;
    logic [7:0] stable[vcd_pkg::MAX_PORTS];
    logic [7:0] cnt_lo[vcd_pkg::MAX_PORTS];
    logic [7:0] cnt_hi[vcd_pkg::MAX_PORTS];
    logic [7:0] latch[vcd_pkg::MAX_PORTS];
    vcd_pkg::vcd_rsp_t expected_q[$];
    int errors;
    int checked;
    int samples;
    int reads;
    int toggles;
    int presses_read;

    function new();
      enable = '0;
      for (int i = 0; i < vcd_pkg::MAX_PORTS; i++) begin
        stable[i] = '0;
        cnt_lo[i] = vcd_pkg::COUNT_RESET;
        cnt_hi[i] = vcd_pkg::COUNT_RESET;
        latch[i]  = '0;
      end
    endfunction

    function void set_enable(logic [3:0] v);
      enable = v;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Advance the per-port vertical counters and build the expected response.
    function void note_request(logic op, logic [1:0] port, logic [7:0] levels, logic [2:0] pin);
      vcd_pkg::vcd_rsp_t rsp;
      logic [7:0] diff;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] wrapped;
      logic [7:0] hit;
      int         p;
      p = int'(port);
      rsp = '0;
      if (p < vcd_pkg::MAX_PORTS) begin
        if (op == vcd_pkg::OP_SAMPLE) begin
          samples++;
          if (enable[p]) begin
            diff      = ~levels ^ stable[p];
            lo        = ~(cnt_lo[p] & diff);
            hi        = lo ^ (cnt_hi[p] & diff);
            cnt_lo[p] = lo;
            cnt_hi[p] = hi;
            wrapped   = diff & hi & lo;
            stable[p] = stable[p] ^ wrapped;
            latch[p]  = latch[p] | (stable[p] & wrapped);
            toggles  += $countones(wrapped);
          end
        end else begin
          reads++;
          hit = latch[p] & (8'h01 << pin);
          latch[p] = latch[p] ^ hit;
          rsp.pressed = (hit != 8'h00);
          if (rsp.pressed) presses_read++;
        end
        rsp.debounced_state = stable[p];
      end
      expected_q.push_back(rsp);
    endfunction

    function void check_result(logic [15:0] data);
      vcd_pkg::vcd_rsp_t want;
      logic       got_pressed;
      logic [7:0] got_state;
      got_pressed = data[0];
      got_state   = data[8:1];
      if (expected_q.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: pressed=%0b state=%02h", got_pressed, got_state);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got_pressed !== want.pressed || got_state !== want.debounced_state) begin
        if (errors < 10)
          $display("mismatch #%0d: expected pressed=%0b state=%02h, got pressed=%0b state=%02h",
                   checked, want.pressed, want.debounced_state, got_pressed, got_state);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;

  debounce_scoreboard sb = new();

  int item_count = 0;
  int hold_cycles = 0;
  int idle_pct = 20;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  vertical_counter_debouncer_top #(.PORTS(vcd_pkg::MAX_PORTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on demand.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_req(logic op, logic [1:0] port, logic [7:0] levels, logic [2:0] pin);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, pin, levels, port};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(op, port, levels, pin);
    item_count++;
    maybe_idle();
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_enable(logic [3:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_enable(v);
  endtask

  // Mostly steady levels held for a few samples with occasional bounce, some reads.
  task automatic random_phase(int target);
    int         start;
    int         kind;
    logic [1:0] p;
    logic [7:0] lv;
    int         reps;
    start = item_count;
    while (item_count - start < target) begin
      kind = $urandom_range(0, 99);
      p    = 2'($urandom_range(0, 3));
      if (kind < 70) begin
        lv   = 8'($urandom);
        reps = $urandom_range(1, 6);
        for (int i = 0; i < reps; i++) begin
          if ($urandom_range(0, 4) == 0)
            send_req(vcd_pkg::OP_SAMPLE, p, lv ^ (8'h01 << $urandom_range(0, 7)), 3'($urandom));
          else
            send_req(vcd_pkg::OP_SAMPLE, p, lv, 3'($urandom));
        end
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(1, 3))
            send_req(vcd_pkg::OP_READ, p, 8'($urandom), 3'($urandom_range(0, 7)));
        end
      end else if (kind < 85) begin
        send_req(vcd_pkg::OP_READ, p, 8'($urandom), 3'($urandom_range(0, 7)));
      end else begin
        send_req(vcd_pkg::OP_SAMPLE, p, 8'($urandom), 3'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled port: sampling is ignored, reads still answer
    idle_pct = 0;
    send_req(vcd_pkg::OP_SAMPLE, 2'd0, 8'h00, 3'd0);
    send_req(vcd_pkg::OP_READ,   2'd0, 8'hFF, 3'd0);

    write_enable(4'hF);
    idle_pct = 20;
    repeat (4) send_req(vcd_pkg::OP_SAMPLE, 2'd0, 8'h00, 3'd7);
    send_req(vcd_pkg::OP_READ, 2'd0, 8'h00, 3'd0);
    send_req(vcd_pkg::OP_READ, 2'd0, 8'h00, 3'd7);
    send_req(vcd_pkg::OP_READ, 2'd0, 8'h00, 3'd7);
    send_req(vcd_pkg::OP_SAMPLE, 2'd3, 8'hFF, 3'd0);
    repeat (4) send_req(vcd_pkg::OP_SAMPLE, 2'd1, 8'hAA, 3'd5);
    send_req(vcd_pkg::OP_READ, 2'd1, 8'hAA, 3'd0);
    send_req(vcd_pkg::OP_READ, 2'd1, 8'hAA, 3'd1);
    // bounce on release: a matching sample reloads the counter
    send_req(vcd_pkg::OP_SAMPLE, 2'd0, 8'hFF, 3'd0);
    send_req(vcd_pkg::OP_SAMPLE, 2'd0, 8'hFF, 3'd0);
    send_req(vcd_pkg::OP_SAMPLE, 2'd0, 8'h00, 3'd0);
    repeat (4) send_req(vcd_pkg::OP_SAMPLE, 2'd0, 8'hFF, 3'd0);
    send_req(vcd_pkg::OP_READ, 2'd2, 8'h55, 3'd3);

    write_enable(4'h0);
    send_req(vcd_pkg::OP_SAMPLE, 2'd2, 8'h00, 3'd0);
    send_req(vcd_pkg::OP_READ,   2'd1, 8'h00, 3'd2);

    write_enable(4'hF);
    idle_pct = 0;
    random_phase(90);

    write_enable(4'($urandom_range(1, 15)));
    idle_pct = 25;
    hold_cycles = LONG_HOLD;
    random_phase(110);

    write_enable(4'h5);
    idle_pct = 10;
    random_phase(60);
    drain();
    random_phase(40);

    write_enable(4'hA);
    idle_pct = 30;
    random_phase(100);

    write_enable(4'($urandom_range(1, 15)));
    idle_pct = 20;
    random_phase(100);

    write_enable(4'h1);
    random_phase(70);

    write_enable(4'h8);
    random_phase(70);

    write_enable(4'hF);
    quiet = 1'b1;
    random_phase(140);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests (%0d samples, %0d reads), %0d results checked, masks 0x0 to 0xF",
             sb.samples + sb.reads, sb.samples, sb.reads, sb.checked);
    $display("%0d debounced toggles, %0d presses read back; long output stall and drain pause",
             sb.toggles, sb.presses_read);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/vcd_pkg.sv
rtl/core/vcd_port.sv
rtl/core/vertical_counter_debouncer_top.sv
bench/tb_top.sv
